FILE: design/polyline_simplify_dp_unit_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the polyline simplifier
// Shared property forms used by the port checker.
// ---------------------------------------------------------------------------
`ifndef POLYLINE_SIMPLIFY_DP_UNIT_DEFINES_SVH
`define POLYLINE_SIMPLIFY_DP_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define PSDP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("psdp check failed");

// Next-cycle implication, disabled while reset is held.
`define PSDP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("psdp check failed");

`endif

FILE: design/psdp_pkg.sv
// ---------------------------------------------------------------------------
// Polyline simplifier package
// Fixed field widths, datapath widths and controller/datapath bundles.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package psdp_pkg;

    localparam int COORD_W  = 12;
    localparam int TOL_W    = 16;
    localparam int DIFF_W   = COORD_W + 1;
    localparam int PROD_W   = 2 * DIFF_W;
    localparam int CROSS_W  = PROD_W;
    localparam int LEN2_W   = PROD_W + 1;
    localparam int TOL2_W   = 2 * TOL_W;
    localparam int LHS_W    = 2 * CROSS_W;
    localparam int RHS_W    = TOL2_W + LEN2_W;
    localparam int CMP_W    = LHS_W + 8;

    localparam logic [TOL_W-1:0] TOL_RESET = 16'd160;

    // Read select codes for the point memory.
    localparam logic [1:0] RD_FIRST = 2'd0;
    localparam logic [1:0] RD_LAST  = 2'd1;
    localparam logic [1:0] RD_SCAN  = 2'd2;
    localparam logic [1:0] RD_KEPT  = 2'd3;

    typedef struct packed {
        logic       store;
        logic       init;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       latch_first;
        logic       setup;
        logic       scan_issue;
        logic       mul;
        logic       keep;
        logic       split;
        logic       pop_load;
        logic       emit_rd_kept;
        logic       emit_load;
    } t_cmd;

    typedef struct packed {
        logic scan_more;
        logic pipe_busy;
        logic is_keep;
        logic stack_more;
        logic out_free;
        logic emit_final;
    } t_stat;

endpackage

FILE: design/psdp_point_if.sv
// ---------------------------------------------------------------------------
// Point channel
// Valid/ready channel carrying one polyline point per word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface psdp_point_if;
    logic                         valid;
    logic                         ready;
    logic [psdp_pkg::COORD_W-1:0] point_x;
    logic [psdp_pkg::COORD_W-1:0] point_y;
    logic                         is_last;

    modport source (output valid, output point_x, output point_y, output is_last,
                    input ready);
    modport sink   (input valid, input point_x, input point_y, input is_last,
                    output ready);
endinterface

FILE: design/psdp_result_if.sv
// ---------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one kept point per word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface psdp_result_if;
    logic                         valid;
    logic                         ready;
    logic [psdp_pkg::COORD_W-1:0] out_x;
    logic [psdp_pkg::COORD_W-1:0] out_y;
    logic                         out_last;

    modport source (output valid, output out_x, output out_y, output out_last,
                    input ready);
    modport sink   (input valid, input out_x, input out_y, input out_last,
                    output ready);
endinterface

FILE: design/psdp_cfg_if.sv
// ---------------------------------------------------------------------------
// Configuration channel
// Valid/ready write channel for the tolerance register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface psdp_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [psdp_pkg::TOL_W-1:0] tolerance;

    modport source (output valid, output tolerance, input ready);
    modport sink   (input valid, input tolerance, output ready);
endinterface

FILE: design/psdp_ctrl.sv
// ---------------------------------------------------------------------------
// Polyline simplifier controller
// Sequences loading, span processing and emission of kept points.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module psdp_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_last,
    output logic            o_in_ready,
    input  psdp_pkg::t_stat i_stat,
    output psdp_pkg::t_cmd  o_cmd
);

    localparam logic [3:0] S_LOAD  = 4'd0;
    localparam logic [3:0] S_INIT  = 4'd1;
    localparam logic [3:0] S_RDF   = 4'd2;
    localparam logic [3:0] S_RDL   = 4'd3;
    localparam logic [3:0] S_SETUP = 4'd4;
    localparam logic [3:0] S_SCAN  = 4'd5;
    localparam logic [3:0] S_DRAIN = 4'd6;
    localparam logic [3:0] S_MUL   = 4'd7;
    localparam logic [3:0] S_CMP   = 4'd8;
    localparam logic [3:0] S_POP   = 4'd9;
    localparam logic [3:0] S_EA    = 4'd10;
    localparam logic [3:0] S_EB    = 4'd11;
    localparam logic [3:0] S_EC    = 4'd12;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_LOAD: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.store = 1'b1;
                    if (i_in_last) begin
                        n_state = S_INIT;
                    end
                end
            end
            S_INIT: begin
                o_cmd.init = 1'b1;
                n_state    = S_RDF;
            end
            S_RDF: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = psdp_pkg::RD_FIRST;
                n_state      = S_RDL;
            end
            S_RDL: begin
                o_cmd.rd_en       = 1'b1;
                o_cmd.rd_sel      = psdp_pkg::RD_LAST;
                o_cmd.latch_first = 1'b1;
                n_state           = S_SETUP;
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state     = S_SCAN;
            end
            S_SCAN: begin
                if (i_stat.scan_more) begin
                    o_cmd.scan_issue = 1'b1;
                    o_cmd.rd_en      = 1'b1;
                    o_cmd.rd_sel     = psdp_pkg::RD_SCAN;
                end else begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_stat.pipe_busy) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_CMP;
            end
            S_CMP: begin
                if (i_stat.is_keep) begin
                    o_cmd.keep = 1'b1;
                    n_state    = i_stat.stack_more ? S_POP : S_EA;
                end else begin
                    o_cmd.split = 1'b1;
                    n_state     = S_RDF;
                end
            end
            S_POP: begin
                o_cmd.pop_load = 1'b1;
                n_state        = S_RDF;
            end
            S_EA: begin
                o_cmd.emit_rd_kept = 1'b1;
                n_state            = S_EB;
            end
            S_EB: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = psdp_pkg::RD_KEPT;
                n_state      = S_EC;
            end
            S_EC: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_load = 1'b1;
                    n_state         = i_stat.emit_final ? S_LOAD : S_EA;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

endmodule

FILE: design/psdp_dpath.sv
// ---------------------------------------------------------------------------
// Polyline simplifier datapath
// Point, stack and kept-index memories, cross-product pipeline and test.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module psdp_dpath #(
    parameter int MAX_POINTS = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  psdp_pkg::t_cmd               i_cmd,
    output psdp_pkg::t_stat              o_stat,
    input  logic [psdp_pkg::TOL_W-1:0]   i_tolerance,
    input  logic [psdp_pkg::COORD_W-1:0] i_point_x,
    input  logic [psdp_pkg::COORD_W-1:0] i_point_y,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [psdp_pkg::COORD_W-1:0] o_x,
    output logic [psdp_pkg::COORD_W-1:0] o_y,
    output logic                         o_last
);

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int CW    = psdp_pkg::COORD_W;
    localparam int DW    = psdp_pkg::DIFF_W;
    localparam int PW    = psdp_pkg::PROD_W;
    localparam int T2W   = psdp_pkg::TOL2_W;
    localparam int LW    = psdp_pkg::LHS_W;
    localparam int RW    = psdp_pkg::RHS_W;

    logic [CW-1:0]    mem_x     [MAX_POINTS];
    logic [CW-1:0]    mem_y     [MAX_POINTS];
    logic [IDX_W-1:0] mem_stack [MAX_POINTS];
    logic [IDX_W-1:0] mem_kept  [MAX_POINTS];

    logic [CNT_W-1:0] r_count;
    logic [IDX_W-1:0] r_first, r_last, r_best_idx, r_kept_rd, r_stack_rd;
    logic [IDX_W:0]   r_i;
    logic [CNT_W-1:0] r_depth, r_kcnt, r_k;
    logic [CW-1:0]    r_rd_x, r_rd_y, r_x1, r_y1;
    logic signed [DW-1:0] r_dx, r_dy;
    logic [PW-1:0]    r_dx2, r_dy2;
    logic [psdp_pkg::LEN2_W-1:0]  r_len2;
    logic [psdp_pkg::TOL2_W-1:0]  r_tol2;
    logic [psdp_pkg::CROSS_W-1:0] r_best, r_c;
    logic [psdp_pkg::LHS_W-1:0]   r_lhs;
    logic [psdp_pkg::RHS_W-1:0]   r_rhs;
    logic             r_v1, r_v2, r_v3;
    logic [IDX_W-1:0] r_idx1, r_idx2, r_idx3;
    logic signed [PW-1:0] r_p1, r_p2;
    logic             r_out_valid;

    logic [IDX_W-1:0] slot, last_init, rd_addr;
    logic signed [DW-1:0] ex, ey;
    logic signed [PW:0]   cdiff;
    logic signed [PW-1:0] sq_x, sq_y;
    logic [psdp_pkg::CMP_W-1:0] lhs_cmp, rhs_cmp;
    logic [CNT_W-1:0] depth_m2, k_p1;

    assign slot = (r_count < CNT_W'(MAX_POINTS)) ? r_count[IDX_W-1:0]
                                                 : IDX_W'(MAX_POINTS - 1);
    assign last_init = IDX_W'(r_count - CNT_W'(1));
    assign depth_m2  = r_depth - CNT_W'(2);
    assign k_p1      = r_k + CNT_W'(1);

    always_comb begin
        case (i_cmd.rd_sel)
            psdp_pkg::RD_FIRST: rd_addr = r_first;
            psdp_pkg::RD_LAST:  rd_addr = r_last;
            psdp_pkg::RD_SCAN:  rd_addr = r_i[IDX_W-1:0];
            psdp_pkg::RD_KEPT:  rd_addr = r_kept_rd;
            default:            rd_addr = r_first;
        endcase
    end

    // Point memory: one write port while loading, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            mem_x[slot] <= i_point_x;
            mem_y[slot] <= i_point_y;
        end
        if (i_cmd.rd_en) begin
            r_rd_x <= mem_x[rd_addr];
            r_rd_y <= mem_y[rd_addr];
        end
    end

    // Split stack memory.
    always_ff @(posedge i_clk) begin
        if (i_cmd.init) begin
            mem_stack[0] <= last_init;
        end else if (i_cmd.split) begin
            mem_stack[r_depth[IDX_W-1:0]] <= r_best_idx;
        end
        if (i_cmd.keep) begin
            r_stack_rd <= mem_stack[depth_m2[IDX_W-1:0]];
        end
    end

    // Kept index memory.
    always_ff @(posedge i_clk) begin
        if (i_cmd.init) begin
            mem_kept[0] <= '0;
        end else if (i_cmd.keep) begin
            mem_kept[r_kcnt[IDX_W-1:0]] <= r_last;
        end
        if (i_cmd.emit_rd_kept) begin
            r_kept_rd <= mem_kept[r_k[IDX_W-1:0]];
        end
    end

    // Control counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_depth     <= '0;
            r_kcnt      <= '0;
            r_k         <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.store && (r_count < CNT_W'(MAX_POINTS))) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_cmd.emit_load && (k_p1 == r_kcnt)) begin
                r_count <= '0;
            end
            if (i_cmd.init) begin
                r_depth <= CNT_W'(1);
                r_kcnt  <= CNT_W'(1);
                r_k     <= '0;
            end else if (i_cmd.keep) begin
                r_depth <= r_depth - CNT_W'(1);
                r_kcnt  <= r_kcnt + CNT_W'(1);
            end else if (i_cmd.split) begin
                r_depth <= r_depth + CNT_W'(1);
            end else if (i_cmd.emit_load) begin
                r_k <= k_p1;
            end
            r_v1 <= i_cmd.scan_issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            if (i_cmd.emit_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign ex    = DW'(signed'({1'b0, r_rd_x})) - DW'(signed'({1'b0, r_x1}));
    assign ey    = DW'(signed'({1'b0, r_rd_y})) - DW'(signed'({1'b0, r_y1}));
    assign cdiff = (PW + 1)'(r_p1) - (PW + 1)'(r_p2);
    assign sq_x  = PW'(r_dx) * PW'(r_dx);
    assign sq_y  = PW'(r_dy) * PW'(r_dy);

    // Span registers and the cross-product pipeline.
    always_ff @(posedge i_clk) begin
        if (i_cmd.init) begin
            r_first <= '0;
            r_last  <= last_init;
        end else if (i_cmd.keep) begin
            r_first <= r_last;
        end else if (i_cmd.split) begin
            r_last <= r_best_idx;
        end else if (i_cmd.pop_load) begin
            r_last <= r_stack_rd;
        end
        if (i_cmd.latch_first) begin
            r_x1 <= r_rd_x;
            r_y1 <= r_rd_y;
        end
        if (i_cmd.setup) begin
            r_dx <= ex;
            r_dy <= ey;
            r_i  <= {1'b0, r_first} + (IDX_W + 1)'(1);
        end else if (i_cmd.scan_issue) begin
            r_i <= r_i + (IDX_W + 1)'(1);
        end
        r_idx1 <= r_i[IDX_W-1:0];
        r_p1   <= PW'(r_dx) * PW'(ey);
        r_p2   <= PW'(r_dy) * PW'(ex);
        r_idx2 <= r_idx1;
        r_c    <= cdiff[PW] ? PW'(-cdiff) : cdiff[PW-1:0];
        r_idx3 <= r_idx2;
        if (i_cmd.setup) begin
            r_best     <= '0;
            r_best_idx <= r_first;
        end else if (r_v3 && (r_c > r_best)) begin
            r_best     <= r_c;
            r_best_idx <= r_idx3;
        end
        r_dx2  <= sq_x;
        r_dy2  <= sq_y;
        r_len2 <= {1'b0, r_dx2} + {1'b0, r_dy2};
        r_tol2 <= T2W'(i_tolerance) * T2W'(i_tolerance);
        if (i_cmd.mul) begin
            r_lhs <= LW'(r_best) * LW'(r_best);
            r_rhs <= RW'(r_tol2) * RW'(r_len2);
        end
    end

    assign lhs_cmp = {r_lhs, 8'd0};
    assign rhs_cmp = psdp_pkg::CMP_W'(r_rhs);

    // Output word register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_load) begin
            o_x    <= r_rd_x;
            o_y    <= r_rd_y;
            o_last <= (k_p1 == r_kcnt);
        end
    end

    assign o_valid = r_out_valid;

    always_comb begin
        o_stat.scan_more  = r_i < {1'b0, r_last};
        o_stat.pipe_busy  = r_v1 | r_v2 | r_v3;
        o_stat.is_keep    = lhs_cmp <= rhs_cmp;
        o_stat.stack_more = r_depth > CNT_W'(1);
        o_stat.out_free   = !r_out_valid || i_ready;
        o_stat.emit_final = (k_p1 == r_kcnt);
    end

endmodule

FILE: design/polyline_simplify_dp_unit.sv
// ---------------------------------------------------------------------------
// Polyline simplifier, Douglas-Peucker
// Top level: tolerance register, controller and datapath.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

// Points are taken one word per cycle and stored in order; the word with
// is_last set closes the polyline and starts the simplification, during which
// no point is taken. Each span is scanned: every interior point passes once
// through the single read port of the point memory and a cross product
// pipeline, so the length of the whole pass is data dependent. Kept points
// then leave one by one, each through a kept index read, a point read and an
// output load that waits while the previous word is stalled; the last word is
// flagged with out_last. A single point comes out twice. Up to MAX_POINTS
// points are held; further points overwrite the last slot. The tolerance
// register is 12.4 fixed point; the user must write it only while idle, and
// the block itself does not enforce this. Its write channel is always ready.
// The memories need no clearing pass.

module polyline_simplify_dp_unit #(
    parameter int MAX_POINTS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    psdp_point_if.sink           i_pt,
    psdp_result_if.source        o_res,
    psdp_cfg_if.sink             i_cfg
);

    // Tolerance register with its documented reset value.
    logic [psdp_pkg::TOL_W-1:0] r_tolerance;

    // Command and status bundles between controller and datapath.
    psdp_pkg::t_cmd  cmd;
    psdp_pkg::t_stat stat;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tolerance <= psdp_pkg::TOL_RESET;
        end else if (i_cfg.valid) begin
            r_tolerance <= i_cfg.tolerance;
        end
    end

    // The controller owns the input handshake; the datapath owns the output
    // word register and all memories.
    psdp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pt.valid),
        .i_in_last  (i_pt.is_last),
        .o_in_ready (i_pt.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    psdp_dpath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_tolerance (r_tolerance),
        .i_point_x   (i_pt.point_x),
        .i_point_y   (i_pt.point_y),
        .o_valid     (o_res.valid),
        .i_ready     (o_res.ready),
        .o_x         (o_res.out_x),
        .o_y         (o_res.out_y),
        .o_last      (o_res.out_last)
    );

endmodule

FILE: design/psdp_checker.sv
// ---------------------------------------------------------------------------
// Polyline simplifier port checker
// Watches the top-level channels and is bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "polyline_simplify_dp_unit_defines.svh"

module psdp_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_in_last,
    input logic i_out_valid,
    input logic i_out_ready
);

    // A stalled result word stays offered.
    `PSDP_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)

    // The closing point stops point intake while the polyline is processed.
    `PSDP_ASSERT_NXT(a_last_stops, i_clk, i_rst_n, i_in_valid && i_in_ready && i_in_last, !i_in_ready)

    // Ordinary points keep the intake open.
    `PSDP_ASSERT_NXT(a_load_open, i_clk, i_rst_n, i_in_valid && i_in_ready && !i_in_last, i_in_ready)

    // A new result word only appears while intake is closed.
    `PSDP_ASSERT_IMP(a_out_phase, i_clk, i_rst_n, $rose(i_out_valid), $past(!i_in_ready))

endmodule

bind polyline_simplify_dp_unit psdp_checker u_psdp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pt.valid),
    .i_in_ready  (i_pt.ready),
    .i_in_last   (i_pt.is_last),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready)
);
